[src/bfa_pkg.sv]
// Shared types and constants for the bitmap first-fit allocator.
`timescale 1ns / 1ps

package bfa_pkg;

   // Default pool depth and the reset value of the managed-cell register.
   localparam int POOL_CELLS_DEF = 64;
   localparam logic [6:0] CELLS_RESET = 7'd64;
   // Largest managed-cell count the 7-bit register can name.
   localparam int CELLS_MAX = 127;

   typedef enum logic {
      CMD_REQUEST = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STAT_GRANTED  = 2'd0,
      STAT_NOMEM    = 2'd1,
      STAT_TOOBIG   = 2'd2,
      STAT_RELEASED = 2'd3
   } status_type;

   typedef struct packed {
      command_type command;
      logic [5:0]  start_index;
      logic [6:0]  block_size;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [5:0] granted_start;
      logic [6:0] free_cells;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_en;
      logic start;
      logic scan_en;
      logic mark_en;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic grant_mark;
      logic mark_done;
   } sts_type;

endpackage

[src/bfa_ctrl.sv]
// Controller state machine of the bitmap first-fit allocator.
`timescale 1ns / 1ps

module bfa_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output bfa_pkg::cmd_type cmd,
   input  bfa_pkg::sts_type sts
);
   import bfa_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = sts.grant_mark ? ST_MARK : ST_RESP;
         end
         ST_MARK: begin
            if (sts.mark_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_SCAN: cmd.scan_en = 1'b1;
         ST_MARK: cmd.mark_en = 1'b1;
         ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/bfa_dp.sv]
// Datapath of the bitmap first-fit allocator: occupancy memory, scan and mark logic.
`timescale 1ns / 1ps

module bfa_dp #(
   parameter int MAP_CELLS = bfa_pkg::POOL_CELLS_DEF,
   parameter int CW = $clog2(MAP_CELLS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  bfa_pkg::req_type req_data,
   input  logic [CW-1:0]    n_cells,
   input  bfa_pkg::cmd_type cmd,
   output bfa_pkg::sts_type sts,
   output bfa_pkg::rsp_type rsp_data
);
   import bfa_pkg::*;

   localparam int AW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;

   // occupancy memory, one bit per cell
   logic map_mem [MAP_CELLS];
   logic rd_data_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic wr_bit;

   command_type  cmd_ff;
   logic [5:0]   start_ff;
   logic [6:0]   size_ff;
   logic [CW-1:0] n_ff;

   logic [CW-1:0] iss_ff, iss_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic          found_ff, found_in;
   logic [AW-1:0] first_ff, first_in;
   logic [CW-1:0] run_ff, run_in;
   logic          run_on_ff, run_on_in;
   logic [CW-1:0] free_ff, free_in;
   logic [6:0]    mark_ff, mark_in;
   logic [AW-1:0] clr_ff, clr_in;
   rsp_type       rsp_ff, rsp_in;

   logic       issue;
   logic [7:0] rng_lo;
   logic [7:0] rng_hi;
   logic       iss_in_rng;
   logic       chk_in_rng;
   logic       cell_free;
   logic       toobig;
   logic       grant_mark;

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_bit;
      rd_data_ff <= map_mem[iss_ff[AW-1:0]];
   end

   assign issue      = cmd.scan_en && (iss_ff < n_ff);
   assign rng_lo     = 8'(start_ff);
   assign rng_hi     = rng_lo + 8'(size_ff);
   assign iss_in_rng = (8'(iss_ff) >= rng_lo) && (8'(iss_ff) < rng_hi);
   assign chk_in_rng = (8'(chk_idx_ff) >= rng_lo) && (8'(chk_idx_ff) < rng_hi);
   // a cell inside the release range counts as free; its write races the read
   assign cell_free  = !rd_data_ff || ((cmd_ff == CMD_RELEASE) && chk_in_rng);
   assign toobig     = 8'(size_ff) > 8'(n_ff);
   assign grant_mark = (cmd_ff == CMD_REQUEST) && (size_ff != 7'd0) && !toobig &&
                       found_ff && (8'(run_ff) >= 8'(size_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_bit  = 1'b0;
      priority if (cmd.clear_en) begin
         wr_en = 1'b1;
      end else if (cmd.mark_en) begin
         wr_en   = 1'b1;
         wr_addr = AW'(8'(first_ff) + 8'(mark_ff));
         wr_bit  = 1'b1;
      end else if (issue && (cmd_ff == CMD_RELEASE) && iss_in_rng) begin
         wr_en   = 1'b1;
         wr_addr = iss_ff[AW-1:0];
      end
   end

   always_comb begin
      iss_in     = iss_ff;
      chk_vld_in = issue;
      chk_idx_in = iss_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      run_in     = run_ff;
      run_on_in  = run_on_ff;
      free_in    = free_ff;
      mark_in    = mark_ff;
      clr_in     = cmd.clear_en ? clr_ff + AW'(1) : clr_ff;
      rsp_in     = rsp_ff;

      if (cmd.start) begin
         iss_in     = '0;
         chk_vld_in = 1'b0;
         found_in   = 1'b0;
         first_in   = '0;
         run_in     = '0;
         run_on_in  = 1'b0;
         free_in    = '0;
         mark_in    = '0;
      end else begin
         if (issue) iss_in = iss_ff + CW'(1);
         if (chk_vld_ff) begin
            free_in = free_ff + CW'(cell_free);
            // track the first free cell and the free run that follows it
            if (!found_ff) begin
               if (cell_free) begin
                  found_in  = 1'b1;
                  first_in  = chk_idx_ff[AW-1:0];
                  run_in    = CW'(1);
                  run_on_in = 1'b1;
               end
            end else if (run_on_ff) begin
               if (cell_free) run_in = run_ff + CW'(1);
               else run_on_in = 1'b0;
            end
         end
         if (cmd.mark_en) mark_in = mark_ff + 7'd1;
      end

      if (cmd.load_rsp) begin
         rsp_in.granted_start = '0;
         rsp_in.free_cells    = grant_mark ? 7'(free_ff) - size_ff : 7'(free_ff);
         priority if (cmd_ff == CMD_RELEASE) begin
            rsp_in.status = STAT_RELEASED;
         end else if (toobig) begin
            rsp_in.status = STAT_TOOBIG;
         end else if (size_ff == 7'd0) begin
            rsp_in.status        = STAT_GRANTED;
            rsp_in.granted_start = found_ff ? 6'(first_ff) : 6'd0;
         end else if (grant_mark) begin
            rsp_in.status        = STAT_GRANTED;
            rsp_in.granted_start = 6'(first_ff);
         end else begin
            rsp_in.status = STAT_NOMEM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff     <= '0;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         run_on_ff  <= 1'b0;
         clr_ff     <= '0;
      end else begin
         iss_ff     <= iss_in;
         chk_vld_ff <= chk_vld_in;
         found_ff   <= found_in;
         run_on_ff  <= run_on_in;
         clr_ff     <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff   <= req_data.command;
         start_ff <= req_data.start_index;
         size_ff  <= req_data.block_size;
         n_ff     <= n_cells;
      end
      chk_idx_ff <= chk_idx_in;
      first_ff   <= first_in;
      run_ff     <= run_in;
      free_ff    <= free_in;
      mark_ff    <= mark_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.clear_done = (clr_ff == AW'(MAP_CELLS - 1));
   assign sts.scan_done  = (iss_ff == n_ff) && !chk_vld_ff;
   assign sts.grant_mark = grant_mark;
   assign sts.mark_done  = (mark_ff == size_ff - 7'd1);
   assign rsp_data       = rsp_ff;

endmodule

[src/bitmap_first_fit_allocator.sv]
// Top level of the bitmap first-fit allocator: register, controller and datapath.
`timescale 1ns / 1ps

// Bitmap first-fit allocator. The occupancy map sits in a one-bit-wide memory that is
// read one cell per cycle, so every word walks the managed cells once, and a granted
// request then writes its marked cells one after another. The single memory read port
// sets this pace. After reset the block runs a clearing pass over min(POOL_CELLS, 127)
// cells with req_ready low; csr writes are taken at any time but must only be issued
// while the block is idle. One result word per input word; a finished result waits in
// an output register until taken.

module bitmap_first_fit_allocator #(
   parameter int POOL_CELLS = bfa_pkg::POOL_CELLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bfa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata
);
   import bfa_pkg::*;

   localparam int MAP_CELLS = (POOL_CELLS < CELLS_MAX) ? POOL_CELLS : CELLS_MAX;
   localparam int CW = $clog2(MAP_CELLS + 1);

   logic [6:0]    cells_ff;
   logic [6:0]    cells_in;
   logic [6:0]    n_clamp;
   logic [CW-1:0] n_cells;
   cmd_type       cmd;
   sts_type       sts;

   assign cells_in = csr_we ? csr_wdata : cells_ff;

   always_ff @(posedge clock) begin
      if (reset) cells_ff <= CELLS_RESET;
      else cells_ff <= cells_in;
   end

   // clamp to the pool depth
   assign n_clamp = (cells_ff > 7'(MAP_CELLS)) ? 7'(MAP_CELLS) : cells_ff;
   assign n_cells = CW'(n_clamp);

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bfa_dp #(
      .MAP_CELLS (MAP_CELLS),
      .CW        (CW)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .n_cells  (n_cells),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

[src/bfa_checker.sv]
// Port-level checker for the bitmap first-fit allocator and its bind.
`timescale 1ns / 1ps

module bfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bfa_pkg::rsp_type rsp_data
);
   import bfa_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // one word in flight: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous word still in work");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_GRANTED) |-> rsp_data.granted_start == 6'd0)
      else $error("granted_start nonzero on a word that was not granted");

   // clearing pass and empty output right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

endmodule

bind bitmap_first_fit_allocator bfa_checker u_bfa_checker (.*);
